/* rtl/gpm_pkg.sv */
// shared types and constants for the glob pattern matcher
`default_nettype none

package gpm_pkg;

    // operation codes carried on the input tuser
    localparam logic [1:0] OP_PAT   = 2'd0;
    localparam logic [1:0] OP_TXT   = 2'd1;
    localparam logic [1:0] OP_MATCH = 2'd2;

    // pattern metacharacters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ANY   = 8'h3f;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_OPEN  = 8'h5b;
    localparam logic [7:0] CH_NOT1  = 8'h21;
    localparam logic [7:0] CH_NOT2  = 8'h5e;
    localparam logic [7:0] CH_CLOSE = 8'h5d;
    localparam logic [7:0] CH_DASH  = 8'h2d;

    typedef struct packed {
        logic start;
        logic ack;
    } seq_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic matched;
    } seq_stat_t;

endpackage

`default_nettype wire

/* rtl/gpm_store.sv */
// byte store with append counter and length-gated synchronous read
`default_nettype none

module gpm_store #(
    parameter int DEPTH = 64,
    parameter int PW    = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic [7:0]    wr_data,
    input  wire logic          clear,
    output logic               full,
    input  wire logic [PW-1:0] rd_addr,
    output logic [7:0]         rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [7:0]    mem [DEPTH];
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic          rd_ok_reg;
    logic [7:0]    mem_q_reg;

    assign full = (len_reg == LW'(DEPTH));

    always_comb
    begin
        len_next = len_reg;
        if (clear)
        begin
            len_next = '0;
        end
        else if (wr_en && !full)
        begin
            len_next = len_reg + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            rd_ok_reg <= (rd_addr < PW'(len_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem[len_reg[AW-1:0]] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr[AW-1:0]];
    end

    // positions at or past the length read as nul
    assign rd_data = rd_ok_reg ? mem_q_reg : 8'h00;

endmodule

`default_nettype wire

/* rtl/gpm_seq.sv */
// match sequencer walking the pattern and text stores
`default_nettype none

module gpm_seq #(
    parameter int PW = 8,
    parameter int TW = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gpm_pkg::seq_ctrl_t ctrl,
    output gpm_pkg::seq_stat_t     stat,
    output logic [PW-1:0]          pat_addr,
    input  wire logic [7:0]        pat_data,
    output logic [TW-1:0]          txt_addr,
    input  wire logic [7:0]        txt_data
);

    import gpm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_STEP  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [PW-1:0] pi_reg, pi_next;
    logic [TW-1:0] ti_reg, ti_next;
    logic          sv_reg, sv_next;
    logic [PW-1:0] sp_reg, sp_next;
    logic [TW-1:0] bt_reg, bt_next;
    logic [7:0]    t_reg, t_next;
    logic [PW-1:0] q_reg, q_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic          pend_reg, pend_next;
    logic [1:0]    wcnt_reg, wcnt_next;
    logic [7:0]    win_reg [3];
    logic [7:0]    win_next [3];
    logic          first_reg, first_next;
    logic          neg_reg, neg_next;
    logic          hit_reg, hit_next;
    logic          chk_reg, chk_next;
    logic          m_reg, m_next;

    always_comb
    begin
        logic mismatch;
        logic issue;
        logic cont;
        logic range_el;

        state_next = state_reg;
        pi_next    = pi_reg;
        ti_next    = ti_reg;
        sv_next    = sv_reg;
        sp_next    = sp_reg;
        bt_next    = bt_reg;
        t_next     = t_reg;
        q_next     = q_reg;
        rp_next    = rp_reg;
        pend_next  = pend_reg;
        wcnt_next  = wcnt_reg;
        win_next   = win_reg;
        first_next = first_reg;
        neg_next   = neg_reg;
        hit_next   = hit_reg;
        chk_next   = chk_reg;
        m_next     = m_reg;
        mismatch   = 1'b0;
        issue      = 1'b0;
        cont       = 1'b0;
        range_el   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    pi_next    = '0;
                    ti_next    = '0;
                    sv_next    = 1'b0;
                    sp_next    = '0;
                    bt_next    = '0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                t_next = txt_data;
                if (txt_data == CH_NUL)
                begin
                    // text exhausted: only trailing stars may remain
                    if (pat_data == CH_STAR)
                    begin
                        pi_next    = pi_reg + PW'(1);
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        m_next     = (pat_data == CH_NUL);
                        state_next = S_DONE;
                    end
                end
                else if (pat_data == CH_ANY)
                begin
                    pi_next    = pi_reg + PW'(1);
                    ti_next    = ti_reg + TW'(1);
                    state_next = S_FETCH;
                end
                else if (pat_data == CH_STAR)
                begin
                    sv_next    = 1'b1;
                    sp_next    = pi_reg;
                    bt_next    = ti_reg;
                    pi_next    = pi_reg + PW'(1);
                    state_next = S_FETCH;
                end
                else if (pat_data == CH_OPEN)
                begin
                    q_next     = pi_reg + PW'(1);
                    rp_next    = pi_reg + PW'(1);
                    pend_next  = 1'b0;
                    wcnt_next  = 2'd0;
                    first_next = 1'b1;
                    neg_next   = 1'b0;
                    hit_next   = 1'b0;
                    chk_next   = 1'b1;
                    state_next = S_FILL;
                end
                else if (pat_data == txt_data)
                begin
                    pi_next    = pi_reg + PW'(1);
                    ti_next    = ti_reg + TW'(1);
                    state_next = S_FETCH;
                end
                else
                begin
                    mismatch = 1'b1;
                end
            end
            S_FILL:
            begin
                // keep three class bytes in the window, one read in flight
                issue = ({1'b0, wcnt_reg} + {2'b00, pend_reg}) < 3'd3;
                if (pend_reg)
                begin
                    case (wcnt_reg)
                        2'd0:    win_next[0] = pat_data;
                        2'd1:    win_next[1] = pat_data;
                        default: win_next[2] = pat_data;
                    endcase
                    wcnt_next = wcnt_reg + 2'd1;
                end
                pend_next = issue;
                if (issue)
                begin
                    rp_next = rp_reg + PW'(1);
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cont = (win_reg[0] != CH_NUL) && ((win_reg[0] != CH_CLOSE) || first_reg);
                range_el = (win_reg[1] == CH_DASH) && (win_reg[2] != CH_NUL)
                           && (win_reg[2] != CH_CLOSE);
                if (chk_reg)
                begin
                    chk_next = 1'b0;
                    if ((win_reg[0] == CH_NOT1) || (win_reg[0] == CH_NOT2))
                    begin
                        neg_next    = 1'b1;
                        q_next      = q_reg + PW'(1);
                        win_next[0] = win_reg[1];
                        win_next[1] = win_reg[2];
                        wcnt_next   = 2'd2;
                        state_next  = S_FILL;
                    end
                end
                else if (!cont)
                begin
                    if ((win_reg[0] == CH_CLOSE) && (hit_reg != neg_reg))
                    begin
                        pi_next    = q_reg + PW'(1);
                        ti_next    = ti_reg + TW'(1);
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        // also covers a class with no closing bracket
                        mismatch = 1'b1;
                    end
                end
                else
                begin
                    first_next = 1'b0;
                    state_next = S_FILL;
                    if (range_el)
                    begin
                        if ((t_reg >= win_reg[0]) && (t_reg <= win_reg[2]))
                        begin
                            hit_next = 1'b1;
                        end
                        q_next    = q_reg + PW'(3);
                        wcnt_next = 2'd0;
                    end
                    else
                    begin
                        if (win_reg[0] == t_reg)
                        begin
                            hit_next = 1'b1;
                        end
                        q_next      = q_reg + PW'(1);
                        win_next[0] = win_reg[1];
                        win_next[1] = win_reg[2];
                        wcnt_next   = 2'd2;
                    end
                end
            end
            S_DONE:
            begin
                if (ctrl.ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // retry from the last star with one more text byte swallowed
        if (mismatch)
        begin
            if (!sv_reg)
            begin
                m_next     = 1'b0;
                state_next = S_DONE;
            end
            else
            begin
                pi_next    = sp_reg + PW'(1);
                bt_next    = bt_reg + TW'(1);
                ti_next    = bt_reg + TW'(1);
                state_next = S_FETCH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pi_reg    <= '0;
            ti_reg    <= '0;
            sv_reg    <= 1'b0;
            sp_reg    <= '0;
            bt_reg    <= '0;
            q_reg     <= '0;
            rp_reg    <= '0;
            pend_reg  <= 1'b0;
            wcnt_reg  <= 2'd0;
            first_reg <= 1'b0;
            neg_reg   <= 1'b0;
            hit_reg   <= 1'b0;
            chk_reg   <= 1'b0;
            m_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pi_reg    <= pi_next;
            ti_reg    <= ti_next;
            sv_reg    <= sv_next;
            sp_reg    <= sp_next;
            bt_reg    <= bt_next;
            q_reg     <= q_next;
            rp_reg    <= rp_next;
            pend_reg  <= pend_next;
            wcnt_reg  <= wcnt_next;
            first_reg <= first_next;
            neg_reg   <= neg_next;
            hit_reg   <= hit_next;
            chk_reg   <= chk_next;
            m_reg     <= m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg   <= t_next;
        win_reg <= win_next;
    end

    assign pat_addr     = (state_reg == S_FILL) ? rp_reg : pi_reg;
    assign txt_addr     = ti_reg;
    assign stat.busy    = (state_reg != S_IDLE);
    assign stat.done    = (state_reg == S_DONE);
    assign stat.matched = m_reg;

endmodule

`default_nettype wire

/* rtl/glob_pattern_matcher_core.sv */
// top level of the glob pattern matcher: stream ports, stores, sequencer
//
// input channel s_*: one transaction per byte load or command. s_tuser holds
// the operation (append pattern byte, append text byte, match, unused code
// ignored) and s_tdata the byte. loads give no result; a load into a full
// store is dropped and flagged for the next match. a match command walks both
// stores with one synchronous read per store and cycle: each pattern/text step
// passes a fetch and an evaluate state; a bracket class is walked element by
// element, filling a three-byte window and stepping over single bytes and
// ranges, and every star retry restarts from just after that star, so the
// match time depends on the data. s_tready stays low meanwhile.
// output channel m_*: one transaction per match, m_tdata bit 0 the match bit,
// m_tuser bit 0 the overflow flag (match bit then low). the result sits in an
// output register; a stalled receiver holds the sequencer in its done state
// and input stays blocked only until the register drains. moving the result
// into the output register clears both stores and the overflow flag.
// reset empties both stores and the output register; store contents are not
// cleared, lengths gate every read.
`default_nettype none

module glob_pattern_matcher_core #(
    parameter int PATTERN_DEPTH = 64,
    parameter int TEXT_DEPTH    = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // ch[7:0]
    input  wire logic [1:0] s_tuser,   // op[1:0]
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // matched[0], zero[7:1]
    output logic            m_tuser    // overflow[0]
);

    import gpm_pkg::*;

    localparam int PW = $clog2(PATTERN_DEPTH) + 2;
    localparam int TW = $clog2(TEXT_DEPTH) + 2;

    seq_ctrl_t     ctrl;
    seq_stat_t     stat;
    logic          accept;
    logic          pat_wr;
    logic          txt_wr;
    logic          pat_full;
    logic          txt_full;
    logic [PW-1:0] pat_addr;
    logic [7:0]    pat_data;
    logic [TW-1:0] txt_addr;
    logic [7:0]    txt_data;
    logic          ovf_reg, ovf_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_match_reg;
    logic          out_ovf_reg;

    assign s_tready   = !stat.busy;
    assign accept     = s_tvalid && s_tready;
    assign pat_wr     = accept && (s_tuser == OP_PAT);
    assign txt_wr     = accept && (s_tuser == OP_TXT);
    assign ctrl.start = accept && (s_tuser == OP_MATCH);
    assign ctrl.ack   = stat.done && (!out_valid_reg || m_tready);

    gpm_store #(
        .DEPTH (PATTERN_DEPTH),
        .PW    (PW)
    ) u_pat_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (pat_wr),
        .wr_data (s_tdata),
        .clear   (ctrl.ack),
        .full    (pat_full),
        .rd_addr (pat_addr),
        .rd_data (pat_data)
    );

    gpm_store #(
        .DEPTH (TEXT_DEPTH),
        .PW    (TW)
    ) u_txt_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (txt_wr),
        .wr_data (s_tdata),
        .clear   (ctrl.ack),
        .full    (txt_full),
        .rd_addr (txt_addr),
        .rd_data (txt_data)
    );

    gpm_seq #(
        .PW (PW),
        .TW (TW)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .stat     (stat),
        .pat_addr (pat_addr),
        .pat_data (pat_data),
        .txt_addr (txt_addr),
        .txt_data (txt_data)
    );

    always_comb
    begin
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        if ((pat_wr && pat_full) || (txt_wr && txt_full))
        begin
            ovf_next = 1'b1;
        end
        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.ack)
        begin
            ovf_next       = 1'b0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ack)
        begin
            out_match_reg <= stat.matched && !ovf_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0000000, out_match_reg};
    assign m_tuser  = out_ovf_reg;

    // a match command always starts the sequencer
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> stat.busy)
    else $error("sequencer did not start on match command");

    // a new result only appears after the sequencer finished
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(stat.done))
    else $error("result without finished match");

    // overflow forces the match bit low
    a_ovf_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> !m_tdata[0])
    else $error("match reported together with overflow");

    // handing a result to the output register clears the overflow flag and the done state
    a_ack_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ack |=> (!ovf_reg && !stat.done))
    else $error("state not cleared after result");

endmodule

`default_nettype wire

/* tb/glob_pattern_matcher_core_tb.sv */
// testbench for glob_pattern_matcher_core: directed table and random load/match runs
`timescale 1ns / 100ps

module glob_pattern_matcher_core_tb;
    import gpm_pkg::*;

    localparam int PAT_DEPTH    = 64;
    localparam int TXT_DEPTH    = 256;
    localparam int HALF_PERIOD  = 6;
    localparam int ITEM_TARGET  = 1250;
    localparam int DRAIN_CYCLES = 50;
    localparam int LIMIT_CYCLES = 3_000_000;

    // unused operation code, the block must ignore it
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_Z    = 8'h7a;

    typedef struct packed {
        logic matched;
        logic overflow;
    } glob_result_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
        logic       typed;
        logic       matched;
        logic       overflow;
    } stim_row_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // ch[7:0]
    logic [1:0] s_tuser  = 2'd0;    // op[1:0]
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // matched[0], zero[7:1]
    logic       m_tuser;            // overflow[0]

    // predictor state
    logic [7:0]   pat_mem [PAT_DEPTH];
    logic [7:0]   txt_mem [TXT_DEPTH];
    int           pat_len     = 0;
    int           txt_len     = 0;
    bit           ovf_pending = 1'b0;
    glob_result_t expected_results[$];

    int error_count  = 0;
    int snd_idle_pct = 36;
    int rcv_idle_pct = 83;

    stim_row_t directed_rows [0:22];

    glob_pattern_matcher_core #(
        .PATTERN_DEPTH (PAT_DEPTH),
        .TEXT_DEPTH    (TXT_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic logic [7:0] pat_byte(input int i);
        if (i < pat_len)
            return pat_mem[i];
        return CH_NUL;
    endfunction

    function automatic logic [7:0] txt_byte(input int i);
        if (i < txt_len)
            return txt_mem[i];
        return CH_NUL;
    endfunction

    // whole-text glob match, only the latest star is retried
    function automatic bit glob_hit();
        int         pi = 0;
        int         ti = 0;
        int         q;
        int         star_pi = 0;
        int         star_ti = 0;
        bit         star_seen = 1'b0;
        bit         neg;
        bit         hit;
        bit         first_el;
        logic [7:0] c;
        logic [7:0] t;
        logic [7:0] hi;
        while (txt_byte(ti) != CH_NUL)
        begin
            c = pat_byte(pi);
            t = txt_byte(ti);
            if (c == CH_ANY)
            begin
                pi++;
                ti++;
                continue;
            end
            if (c == CH_STAR)
            begin
                star_seen = 1'b1;
                star_pi   = pi;
                star_ti   = ti;
                pi++;
                continue;
            end
            if (c == CH_OPEN)
            begin
                q        = pi + 1;
                neg      = (pat_byte(q) == CH_NOT1) || (pat_byte(q) == CH_NOT2);
                hit      = 1'b0;
                first_el = 1'b1;
                if (neg)
                    q++;
                while (pat_byte(q) != CH_NUL && (pat_byte(q) != CH_CLOSE || first_el))
                begin
                    hi = pat_byte(q + 2);
                    // a dash only forms a range when a real upper bound follows
                    if (pat_byte(q + 1) == CH_DASH && hi != CH_NUL && hi != CH_CLOSE)
                    begin
                        if (t >= pat_byte(q) && t <= hi)
                            hit = 1'b1;
                        q += 2;
                    end
                    else if (pat_byte(q) == t)
                        hit = 1'b1;
                    first_el = 1'b0;
                    q++;
                end
                if (pat_byte(q) == CH_CLOSE && hit != neg)
                begin
                    pi = q + 1;
                    ti++;
                    continue;
                end
            end
            else if (c == t)
            begin
                pi++;
                ti++;
                continue;
            end
            if (!star_seen)
                return 1'b0;
            pi = star_pi + 1;
            star_ti++;
            ti = star_ti;
        end
        while (pat_byte(pi) == CH_STAR)
            pi++;
        return pat_byte(pi) == CH_NUL;
    endfunction

    // updates the predictor for one accepted transaction, returns 1 when a result is due
    function automatic bit apply_item(input logic [1:0] op, input logic [7:0] ch,
                                      output glob_result_t res);
        res = '0;
        case (op)
            OP_PAT:
                if (pat_len < PAT_DEPTH)
                begin
                    pat_mem[pat_len] = ch;
                    pat_len++;
                end
                else
                    ovf_pending = 1'b1;
            OP_TXT:
                if (txt_len < TXT_DEPTH)
                begin
                    txt_mem[txt_len] = ch;
                    txt_len++;
                end
                else
                    ovf_pending = 1'b1;
            OP_MATCH:
            begin
                res.overflow = ovf_pending;
                res.matched  = !ovf_pending && glob_hit();
                pat_len      = 0;
                txt_len      = 0;
                ovf_pending  = 1'b0;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // called just after a falling edge, returns just after a falling edge once the item is accepted
    task automatic drive_item(input logic [1:0] op, input logic [7:0] ch);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= ch;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_predicted(input logic [1:0] op, input logic [7:0] ch);
        glob_result_t res;
        drive_item(op, ch);
        if (apply_item(op, ch, res))
            expected_results.push_back(res);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (expected_results.size() != 0);
    endtask

    function automatic logic [7:0] rand_letter();
        return CH_A + 8'($urandom_range(0, 3));
    endfunction

    function automatic logic [7:0] rand_pat_byte();
        case ($urandom_range(0, 15))
            0:       return CH_ANY;
            1, 2:    return CH_STAR;
            3:       return CH_OPEN;
            4:       return CH_NOT1;
            5:       return CH_NOT2;
            6:       return CH_CLOSE;
            7:       return CH_DASH;
            8:       return 8'($urandom_range(0, 255));
            default: return rand_letter();
        endcase
    endfunction

    function automatic logic [7:0] rand_txt_byte();
        case ($urandom_range(0, 11))
            10:      return rand_pat_byte();
            11:      return 8'($urandom_range(0, 255));
            default: return rand_letter();
        endcase
    endfunction

    // result side: ready toggled at the falling edge, transactions checked at the rising edge
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);

    always @(posedge clk)
    begin : result_check
        glob_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result transaction with none outstanding");
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata !== {7'd0, want.matched})
                    report_mismatch($sformatf("m_tdata got %h, want matched %0b",
                                              m_tdata, want.matched));
                if (m_tuser !== want.overflow)
                    report_mismatch($sformatf("overflow got %b, want %0b",
                                              m_tuser, want.overflow));
            end
        end
    end

    initial
    begin
        #(2 * HALF_PERIOD * LIMIT_CYCLES);
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        glob_result_t res;
        logic [7:0]   pat_q[$];
        logic [7:0]   txt_q[$];
        logic [7:0]   b;
        int           random_items = 0;
        int           seq_no       = 0;
        int           cur_phase    = 0;
        int           phase;
        int           pat_n;
        int           txt_n;
        int           idx;
        bit           forced;

        directed_rows = '{
            // empty text against empty pattern
            '{OP_MATCH, 8'h00,    1'b1, 1'b1, 1'b0},
            '{OP_PAT,   CH_ANY,   1'b0, 1'b0, 1'b0},
            '{OP_TXT,   8'hff,    1'b0, 1'b0, 1'b0},
            '{OP_MATCH, 8'hff,    1'b1, 1'b1, 1'b0},
            '{OP_PAT,   CH_STAR,  1'b0, 1'b0, 1'b0},
            '{OP_MATCH, 8'h00,    1'b0, 1'b0, 1'b0},
            // leading close bracket is literal, class never terminated
            '{OP_PAT,   CH_OPEN,  1'b0, 1'b0, 1'b0},
            '{OP_PAT,   CH_CLOSE, 1'b0, 1'b0, 1'b0},
            '{OP_PAT,   CH_A,     1'b0, 1'b0, 1'b0},
            '{OP_TXT,   CH_CLOSE, 1'b0, 1'b0, 1'b0},
            '{OP_MATCH, 8'h00,    1'b0, 1'b0, 1'b0},
            // negated range with an ignored code in between
            '{OP_PAT,   CH_OPEN,  1'b0, 1'b0, 1'b0},
            '{OP_PAT,   CH_NOT2,  1'b0, 1'b0, 1'b0},
            '{OP_PAT,   CH_A,     1'b0, 1'b0, 1'b0},
            '{OP_PAT,   CH_DASH,  1'b0, 1'b0, 1'b0},
            '{OP_PAT,   CH_Z,     1'b0, 1'b0, 1'b0},
            '{OP_PAT,   CH_CLOSE, 1'b0, 1'b0, 1'b0},
            '{OP_TXT,   8'h01,    1'b0, 1'b0, 1'b0},
            '{OP_NONE,  8'hfe,    1'b0, 1'b0, 1'b0},
            '{OP_MATCH, 8'h00,    1'b0, 1'b0, 1'b0},
            // stored zero byte ends the pattern early
            '{OP_PAT,   CH_NUL,   1'b0, 1'b0, 1'b0},
            '{OP_TXT,   CH_X,     1'b0, 1'b0, 1'b0},
            '{OP_MATCH, 8'h00,    1'b0, 1'b0, 1'b0}
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            drive_item(directed_rows[i].op, directed_rows[i].ch);
            if (apply_item(directed_rows[i].op, directed_rows[i].ch, res))
            begin
                if (directed_rows[i].typed)
                begin
                    res.matched  = directed_rows[i].matched;
                    res.overflow = directed_rows[i].overflow;
                end
                expected_results.push_back(res);
            end
        end

        while (random_items < ITEM_TARGET)
        begin
            phase = random_items * 3 / ITEM_TARGET;
            if (phase != cur_phase)
            begin
                // hold the sender until every outstanding result is back
                wait_for_results();
                cur_phase = phase;
                if (phase == 1)
                begin
                    snd_idle_pct = 83;
                    rcv_idle_pct = 36;
                end
                else
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            end

            forced = 1'b1;
            if (seq_no == 5)
            begin
                pat_n = PAT_DEPTH + $urandom_range(1, 4);
                txt_n = $urandom_range(0, 6);
            end
            else if (seq_no == 9)
            begin
                pat_n = $urandom_range(0, 6);
                txt_n = TXT_DEPTH + $urandom_range(1, 3);
            end
            else if ($urandom_range(0, 59) == 0)
            begin
                pat_n = $urandom_range(40, PAT_DEPTH);
                txt_n = $urandom_range(150, TXT_DEPTH);
            end
            else
            begin
                forced = 1'b0;
                pat_n  = $urandom_range(0, 8);
                txt_n  = $urandom_range(0, 14);
            end
            seq_no++;

            pat_q.delete();
            txt_q.delete();
            for (int k = 0; k < pat_n; k++)
                pat_q.push_back(rand_pat_byte());

            if (!forced && $urandom_range(0, 1))
            begin
                // text shaped after the pattern so that matches are common
                foreach (pat_q[k])
                begin
                    if (pat_q[k] == CH_STAR)
                        repeat ($urandom_range(0, 3)) txt_q.push_back(rand_letter());
                    else if (pat_q[k] inside {CH_ANY, CH_OPEN, CH_NOT1, CH_NOT2,
                                              CH_CLOSE, CH_DASH})
                        txt_q.push_back(rand_letter());
                    else
                        txt_q.push_back(pat_q[k]);
                end
                if (txt_q.size() != 0 && $urandom_range(0, 3) == 0)
                begin
                    idx        = $urandom_range(0, txt_q.size() - 1);
                    txt_q[idx] = rand_txt_byte();
                end
            end
            else
                for (int k = 0; k < txt_n; k++)
                    txt_q.push_back(rand_txt_byte());

            while (pat_q.size() != 0 || txt_q.size() != 0)
            begin
                if ($urandom_range(0, 24) == 0)
                    send_predicted(OP_NONE, 8'($urandom_range(0, 255)));
                if (txt_q.size() == 0 || (pat_q.size() != 0 && $urandom_range(0, 1)))
                begin
                    b = pat_q.pop_front();
                    send_predicted(OP_PAT, b);
                end
                else
                begin
                    b = txt_q.pop_front();
                    send_predicted(OP_TXT, b);
                end
                random_items++;
            end

            // now and then no match, so the next run appends to the same stores
            if ($urandom_range(0, 19) != 0)
            begin
                send_predicted(OP_MATCH, 8'($urandom_range(0, 255)));
                random_items++;
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
